@@ src/signed_int_to_decimal_ascii_top_assert.svh @@
// Assertion macros used by the decimal text converter back end.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is held.
`define SIDTA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checked implication on a registered condition, disabled while reset is held.
`define SIDTA_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
    else $error(msg);
`else
`define SIDTA_ASSERT(lbl, clk, rstn, prop, msg)
`define SIDTA_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)
`endif
`endif

@@ src/sidta_pkg.sv @@
// Shared types and constants of the decimal text converter.
package sidta_pkg;

  localparam int MAG_W       = 32;
  localparam int NUM_DIGITS  = 10;
  localparam int DIGIT_W     = 4;
  localparam int DIGIT_IDX_W = 4;
  localparam int CODE_W      = 8;
  localparam int TOTAL_W     = 4;
  localparam int STEP_W      = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CODE_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CODE_W-1:0] ASCII_MINUS = 8'd45;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } item_t;

endpackage

@@ src/sidta_front.sv @@
// Front end: accepts an integer and splits it into sign and magnitude.
module sidta_front (
  input  logic                                  in_valid,
  input  logic signed [sidta_pkg::MAG_W-1:0]    in_value,
  output logic                                  in_stall,
  input  logic                                  q_full,
  output logic                                  q_push,
  output sidta_pkg::item_t                      q_item
);

  logic [sidta_pkg::MAG_W-1:0] raw;

  assign raw      = sidta_pkg::MAG_W'(unsigned'(in_value));
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Two's complement negation stays exact for the most negative value.
  always_comb begin
    q_item.neg = raw[sidta_pkg::MAG_W-1];
    q_item.mag = q_item.neg ? (~raw + sidta_pkg::MAG_W'(1)) : raw;
  end

endmodule

@@ src/sidta_queue.sv @@
// Short queue of classified values between front end and converter.
module sidta_queue #(
  parameter int DEPTH = sidta_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sidta_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output sidta_pkg::item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sidta_pkg::item_t   slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ src/sidta_back.sv @@
// Back end: shift-and-add-3 conversion to BCD, then character emission.
`include "signed_int_to_decimal_ascii_top_assert.svh"
module sidta_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  sidta_pkg::item_t                    q_item,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sidta_pkg::CODE_W-1:0]        out_char_code,
  output logic                                out_last_char,
  output logic [sidta_pkg::TOTAL_W-1:0]       out_char_total
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  localparam int ND = sidta_pkg::NUM_DIGITS;
  localparam int DW = sidta_pkg::DIGIT_W;
  localparam int IW = sidta_pkg::DIGIT_IDX_W;

  logic [2:0]                     state_r, state_nxt;
  logic [sidta_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [sidta_pkg::MAG_W-1:0]    shift_r, shift_nxt;
  logic [DW-1:0]                  bcd_r [ND];
  logic [DW-1:0]                  bcd_nxt [ND];
  logic [DW-1:0]                  adj [ND];
  logic                           neg_r, neg_nxt;
  logic [IW-1:0]                  pos_r, pos_nxt;
  logic [sidta_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [IW-1:0]                  ndig;
  logic                           slot_free;
  logic                           load_out;
  logic [sidta_pkg::CODE_W-1:0]   code_nxt;
  logic                           last_nxt;
  logic [sidta_pkg::TOTAL_W-1:0]  tot_nxt;

  logic                           out_valid_r;
  logic [sidta_pkg::CODE_W-1:0]   out_code_r;
  logic                           out_last_r;
  logic [sidta_pkg::TOTAL_W-1:0]  out_total_r;

  assign slot_free      = !out_valid_r || !out_stall;
  assign q_pop          = (state_r == ST_IDLE) && q_valid;
  assign out_valid      = out_valid_r;
  assign out_char_code  = out_code_r;
  assign out_last_char  = out_last_r;
  assign out_char_total = out_total_r;

  // Correction for one shift step: add 3 to each BCD digit of 5 or more; the FSM shifts.
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      adj[i] = (bcd_r[i] >= DW'(5)) ? bcd_r[i] + DW'(3) : bcd_r[i];
    end
  end

  // Count significant digits; zero still has one.
  always_comb begin
    ndig = IW'(1);
    for (int i = 1; i < ND; i++) begin
      if (bcd_r[i] != '0) begin
        ndig = IW'(i + 1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    shift_nxt = shift_r;
    neg_nxt   = neg_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    for (int i = 0; i < ND; i++) begin
      bcd_nxt[i] = bcd_r[i];
    end
    load_out = 1'b0;
    code_nxt = sidta_pkg::ASCII_MINUS;
    last_nxt = 1'b0;
    tot_nxt  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          shift_nxt = q_item.mag;
          neg_nxt   = q_item.neg;
          step_nxt  = '0;
          for (int i = 0; i < ND; i++) begin
            bcd_nxt[i] = '0;
          end
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt[0] = {adj[0][DW-2:0], shift_r[sidta_pkg::MAG_W-1]};
        for (int i = 1; i < ND; i++) begin
          bcd_nxt[i] = {adj[i][DW-2:0], adj[i-1][DW-1]};
        end
        shift_nxt = {shift_r[sidta_pkg::MAG_W-2:0], 1'b0};
        step_nxt  = step_r + 1'b1;
        if (step_r == sidta_pkg::STEP_W'(sidta_pkg::MAG_W - 1)) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        pos_nxt   = ndig - 1'b1;
        total_nxt = sidta_pkg::TOTAL_W'(ndig) + sidta_pkg::TOTAL_W'(neg_r);
        state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        code_nxt = sidta_pkg::ASCII_ZERO + sidta_pkg::CODE_W'(bcd_r[pos_r]);
        last_nxt = (pos_r == '0);
        tot_nxt  = last_nxt ? total_r : '0;
        if (slot_free) begin
          load_out = 1'b1;
          if (last_nxt) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    shift_r <= shift_nxt;
    neg_r   <= neg_nxt;
    pos_r   <= pos_nxt;
    total_r <= total_nxt;
    for (int i = 0; i < ND; i++) begin
      bcd_r[i] <= bcd_nxt[i];
    end
    if (load_out) begin
      out_code_r  <= code_nxt;
      out_last_r  <= last_nxt;
      out_total_r <= tot_nxt;
    end
  end

  `SIDTA_ASSERT(a_minus_not_last, clk, rst_n, !(out_valid_r && out_code_r == sidta_pkg::ASCII_MINUS) || !out_last_r, "minus sign flagged as last character")
  `SIDTA_ASSERT(a_total_on_last, clk, rst_n, !(out_valid_r && out_last_r) || (out_total_r != '0 && out_total_r <= sidta_pkg::TOTAL_W'(11)), "character total out of range on last character")
  `SIDTA_ASSERT(a_total_zero_mid, clk, rst_n, !(out_valid_r && !out_last_r) || (out_total_r == '0), "character total set before last character")
  `SIDTA_ASSERT_NEXT(a_conv_done, clk, rst_n, state_r == ST_CONV && step_r == sidta_pkg::STEP_W'(sidta_pkg::MAG_W - 1), state_r == ST_COUNT, "conversion did not end after the last shift step")

endmodule

@@ src/signed_int_to_decimal_ascii_top.sv @@
// Signed 32-bit integer to decimal ASCII text converter, one character per transaction.
// Each value yields its decimal text most significant character first: a minus sign for
// negative values, no leading zeros, a single '0' for zero. The last character carries
// out_last_char and the character count. The single bit-serial BCD converter works on one
// value at a time: a load, 32 shift-and-add-3 steps and a digit count, then its 1 to 11
// characters go out one by one as the output accepts them. A short queue in front of the
// converter takes the next values while the current one is worked on.
module signed_int_to_decimal_ascii_top #(
  parameter int QUEUE_DEPTH = sidta_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic signed [sidta_pkg::MAG_W-1:0]   in_value,
  output logic                                 in_stall,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sidta_pkg::CODE_W-1:0]         out_char_code,
  output logic                                 out_last_char,
  output logic [sidta_pkg::TOTAL_W-1:0]        out_char_total
);

  logic              q_push;
  logic              q_full;
  sidta_pkg::item_t  push_item;
  sidta_pkg::item_t  head_item;
  logic              head_valid;
  logic              pop;

  sidta_front u_front (
    .in_valid (in_valid),
    .in_value (in_value),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  sidta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  sidta_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (head_valid),
    .q_item         (head_item),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char),
    .out_char_total (out_char_total)
  );

endmodule

@@ sim/signed_int_to_decimal_ascii_checker.sv @@
// Scoreboard for the decimal text converter: predicts characters and compares results.
module signed_int_to_decimal_ascii_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [sidta_pkg::MAG_W-1:0]         in_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [sidta_pkg::CODE_W-1:0]        out_char_code,
  input  logic                                out_last_char,
  input  logic [sidta_pkg::TOTAL_W-1:0]       out_char_total,
  output int                                  mismatches,
  output int                                  chars_pending
);

  localparam int RADIX = 10;

  typedef struct packed {
    logic [sidta_pkg::CODE_W-1:0]  code;
    logic                          last;
    logic [sidta_pkg::TOTAL_W-1:0] total;
  } glyph_t;

  glyph_t chars_due[$];

  initial begin
    mismatches    = 0;
    chars_pending = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Spell one value as decimal text and queue its characters.
  function automatic void spell_decimal(input logic [sidta_pkg::MAG_W-1:0] value);
    logic                                neg;
    logic [sidta_pkg::MAG_W-1:0]         mag;
    logic [sidta_pkg::DIGIT_W-1:0]       digs [sidta_pkg::NUM_DIGITS];
    int                                  ndig;
    int                                  total;
    int                                  k;
    glyph_t                              g;
    neg  = value[sidta_pkg::MAG_W-1];
    mag  = neg ? (~value + 1'b1) : value;
    ndig = 0;
    do begin
      digs[ndig] = sidta_pkg::DIGIT_W'(mag % RADIX);
      mag        = mag / RADIX;
      ndig++;
    end while (mag != 0 && ndig < sidta_pkg::NUM_DIGITS);
    total = ndig + (neg ? 1 : 0);
    k     = 0;
    if (neg) begin
      g.code  = sidta_pkg::ASCII_MINUS;
      g.last  = 1'b0;
      g.total = '0;
      chars_due.push_back(g);
      k = 1;
    end
    for (int d = ndig; d > 0; d--) begin
      g.code  = sidta_pkg::ASCII_ZERO + sidta_pkg::CODE_W'(digs[d-1]);
      g.last  = (k + 1 == total);
      g.total = g.last ? sidta_pkg::TOTAL_W'(total) : '0;
      chars_due.push_back(g);
      k++;
    end
  endfunction

  always @(posedge clk) begin
    glyph_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        spell_decimal(in_value);
      if (out_valid && !out_stall) begin
        if (chars_due.size() == 0) begin
          report_mismatch("unexpected transaction, char_code", out_char_code, -1);
        end else begin
          want = chars_due.pop_front();
          if (out_char_code !== want.code)
            report_mismatch("char_code", out_char_code, want.code);
          if (out_last_char !== want.last)
            report_mismatch("last_char", out_last_char, want.last);
          if (out_char_total !== want.total)
            report_mismatch("char_total", out_char_total, want.total);
        end
      end
    end
    chars_pending <= chars_due.size();
  end

endmodule

@@ sim/signed_int_to_decimal_ascii_top_tb.sv @@
// Testbench top for the decimal text converter: stimulus, idling, watchdog and verdict.
module signed_int_to_decimal_ascii_top_tb;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 35;

  logic                                  clk       = 1'b0;
  logic                                  rst_n     = 1'b0;
  logic                                  in_valid  = 1'b0;
  logic signed [sidta_pkg::MAG_W-1:0]    in_value  = '0;
  logic                                  in_stall;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic [sidta_pkg::CODE_W-1:0]          out_char_code;
  logic                                  out_last_char;
  logic [sidta_pkg::TOTAL_W-1:0]         out_char_total;

  int mismatches;
  int chars_pending;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_ticket   = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_int_to_decimal_ascii_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_value       (in_value),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char),
    .out_char_total (out_char_total)
  );

  signed_int_to_decimal_ascii_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char),
    .out_char_total (out_char_total),
    .mismatches     (mismatches),
    .chars_pending  (chars_pending)
  );

  // Receiver: random stalls, plus a long hold whenever a new ticket is raised.
  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("signed_int_to_decimal_ascii_top_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_value(input logic [sidta_pkg::MAG_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly values of a chosen digit count, some raw words and some extremes.
  function automatic logic [sidta_pkg::MAG_W-1:0] pick_value();
    int                          kind;
    int                          ndig;
    logic [sidta_pkg::MAG_W-1:0] lim;
    logic [sidta_pkg::MAG_W-1:0] mag;
    kind = $urandom_range(9);
    if (kind < 4)
      return $urandom;
    if (kind == 9) begin
      case ($urandom_range(5))
        0:       return 32'h0000_0000;
        1:       return 32'h8000_0000;
        2:       return 32'h7fff_ffff;
        3:       return 32'hffff_ffff;
        4:       return 32'h0000_0001;
        default: return 32'h8000_0001;
      endcase
    end
    ndig = $urandom_range(10, 1);
    if (ndig == 10) begin
      mag = $urandom_range(32'h7fff_ffff, 32'd1000000000);
    end else begin
      lim = 1;
      repeat (ndig) lim = lim * 10;
      mag = $urandom_range(lim - 1, lim / 10);
    end
    return $urandom_range(1) ? (~mag + 1'b1) : mag;
  endfunction

  initial begin
    logic [sidta_pkg::MAG_W-1:0] directed [];
    int idle_set [4];
    int stall_set [4];

    directed = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99, 32'd100,
      32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
      -32'sd1000000000, 32'd1999999999, 32'd12345, -32'sd54321, 32'h5555_5555,
      32'haaaa_aaaa, 32'd1000000009, -32'sd1000000001
    };
    idle_set  = '{0, 48, 0, 17};
    stall_set = '{0, 0, 48, 17};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_value(directed[i]);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_set[phase];
      stall_pct    <= stall_set[phase];
      // Hold the receiver off while values keep coming, so the input backs up.
      if (phase == 0)
        hold_ticket <= hold_ticket + 1;
      repeat (PHASE_ITEMS) send_value(pick_value());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("signed_int_to_decimal_ascii_top_tb: done, clean");
    else
      $display("signed_int_to_decimal_ascii_top_tb: done, errors");
    $finish;
  end

endmodule
